FILE: rtl/core/va2f4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va2f4_pkg
// Format codes, pipeline types and conversion helpers for the attribute
// converter.
// ----------------------------------------------------------------------------
package va2f4_pkg;

    typedef enum logic [3:0] {
        FMT_UNKNOWN    = 4'd0,
        FMT_RGB32F     = 4'd1,
        FMT_RGBA32F    = 4'd2,
        FMT_RG32F      = 4'd3,
        FMT_RGBA32U    = 4'd4,
        FMT_RG16F      = 4'd5,
        FMT_RGBA16F    = 4'd6,
        FMT_RGBA8UNORM = 4'd7,
        FMT_RGBA8U     = 4'd8,
        FMT_R32U       = 4'd9,
        FMT_R16U       = 4'd10
    } t_fmt;

    localparam logic [31:0] ONE_F32 = 32'h3f80_0000;

    // Stage 1 -> stage 2 item: checked and classified, raw lanes kept.
    typedef struct packed {
        logic        ok;
        logic [3:0]  fmt;
        logic [127:0] data;
    } t_s1;

    // Stage 2 -> stage 3 item: per-lane partial results.
    typedef struct packed {
        logic        ok;
        logic [3:0]  fmt;
        logic [127:0] data;
        logic [3:0][4:0]  lz;     // leading zero count of each u32 lane
        logic [3:0][31:0] half_f; // widened halves
        logic [3:0][31:0] unorm_f;
    } t_s2;

    typedef struct packed {
        logic        ok;
        logic [3:0][31:0] c;
    } t_res;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [10:0] sh;
        logic [7:0]  e;
        ex  = h[14:10];
        man = h[9:0];
        lz  = 4'd0;
        for (int i = 9; i >= 0; i--) begin
            if (man[i] && lz == 4'd0 && (man >> i) == 10'd1) begin
                lz = 4'(10 - i);
            end
        end
        sh = {1'b0, man} << lz;
        e  = 8'd113 - 8'(lz);
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                return {h[15], 31'd0};
            end
            return {h[15], e, sh[9:0], 13'd0};
        end
        if (ex == 5'h1f) begin
            return {h[15], 8'hff, man, 13'd0};
        end
        return {h[15], 8'(ex) + 8'd112, man, 13'd0};
    endfunction

    // Nearest single to b/255, from shifts and adds only.
    function automatic logic [31:0] unorm8_to_single(input logic [7:0] b);
        logic [8:0]  n;
        logic [3:0]  k;
        logic [31:0] q;
        if (b == 8'd0) begin
            return 32'd0;
        end
        n = {1'b0, b};
        k = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (n < 9'd255) begin
                n = n << 1;
                k = k + 4'd1;
            end
        end
        // n*2^23/255 = n*(2^15 + 2^7) + 128*n/255, and the last term rounds
        // to n/2 + 1 for every n in 255..510
        q = ({23'd0, n} << 15) + ({23'd0, n} << 7) + {24'd0, n[8:1]} + 32'd1;
        return ({24'd0, 8'd126 - 8'(k)} << 23) + q;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/va2f4_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va2f4_check
// Bounds check against the vertex stride and format classification.
// ----------------------------------------------------------------------------
module va2f4_check
    import va2f4_pkg::*;
(
    input  wire logic        [3:0]   i_fmt,
    input  wire logic signed [8:0]   i_off,
    input  wire logic        [4:0]   i_size,
    input  wire logic        [127:0] i_data,
    input  wire logic        [7:0]   i_stride,
    output t_s1                      o_s1
);
    logic [9:0] w_end;
    logic       w_fmt_ok;

    assign w_end = {2'b0, i_off[7:0]} + {5'b0, i_size};

    always_comb begin
        unique case (i_fmt)
            FMT_RGB32F, FMT_RGBA32F, FMT_RG32F, FMT_RGBA32U,
            FMT_RG16F, FMT_RGBA16F, FMT_RGBA8UNORM: w_fmt_ok = 1'b1;
            default:                                w_fmt_ok = 1'b0;
        endcase
    end

    assign o_s1.ok   = !i_off[8] && (i_size != 5'd0) && (w_end <= {2'b0, i_stride})
                       && w_fmt_ok;
    assign o_s1.fmt  = i_fmt;
    assign o_s1.data = i_data;
endmodule
`default_nettype wire

FILE: rtl/core/va2f4_lanes.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va2f4_lanes
// Per-lane front work: u32 leading zero counts, half widening, unorm scaling.
// ----------------------------------------------------------------------------
module va2f4_lanes
    import va2f4_pkg::*;
(
    input  wire t_s1 i_s1,
    output t_s2 o_s2
);
    always_comb begin
        o_s2.ok   = i_s1.ok;
        o_s2.fmt  = i_s1.fmt;
        o_s2.data = i_s1.data;
        for (int l = 0; l < 4; l++) begin
            o_s2.lz[l] = 5'd0;
            for (int b = 0; b < 32; b++) begin
                if (i_s1.data[32*l + b]) begin
                    o_s2.lz[l] = 5'(31 - b);
                end
            end
            o_s2.half_f[l]  = half_to_single(i_s1.data[16*l +: 16]);
            o_s2.unorm_f[l] = unorm8_to_single(i_s1.data[8*l +: 8]);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/va2f4_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va2f4_pack
// u32 normalize and round to nearest even, then per-format selection.
// ----------------------------------------------------------------------------
module va2f4_pack
    import va2f4_pkg::*;
(
    input  wire t_s2  i_s2,
    output t_res o_res
);
    logic [3:0][31:0] w_u;
    logic [31:0] w_word;
    logic [31:0] w_norm;
    logic [4:0]  w_m;
    logic        w_up;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_word = i_s2.data[32*l +: 32];
            w_norm = w_word << i_s2.lz[l];
            w_m    = 5'd31 - i_s2.lz[l];
            // guard is bit 7, sticky below it, lsb bit 8
            w_up   = w_norm[7] && ((w_norm[6:0] != 7'd0) || w_norm[8]);
            if (w_word == 32'd0) begin
                w_u[l] = 32'd0;
            end else begin
                // mantissa carry into the exponent falls out of the add
                w_u[l] = ({24'd0, 8'd126 + 8'(w_m)} << 23)
                         + {8'd0, w_norm[31:8]} + {31'd0, w_up};
            end
        end
        o_res.ok = i_s2.ok;
        o_res.c  = '0;
        if (i_s2.ok) begin
            unique case (i_s2.fmt)
                FMT_RGB32F: o_res.c = {ONE_F32, i_s2.data[95:0]};
                FMT_RGBA32F: o_res.c = i_s2.data;
                FMT_RG32F: o_res.c = {64'd0, i_s2.data[63:0]};
                FMT_RGBA32U: o_res.c = w_u;
                FMT_RG16F: o_res.c = {64'd0, i_s2.half_f[1], i_s2.half_f[0]};
                FMT_RGBA16F: o_res.c = i_s2.half_f;
                FMT_RGBA8UNORM: o_res.c = i_s2.unorm_f;
                default: o_res.c = '0;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/vertex_attribute_to_float4.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_attribute_to_float4
// Converts one fetched vertex attribute into four IEEE singles.
// ----------------------------------------------------------------------------
// One item per cycle while the output is not stalled. From input accept to output
// valid an item passes a check stage, a lane stage (half widening, unorm scaling,
// leading zero count) and a rounding/select stage, each ending in a register.
// The pipeline advances whenever the output register is empty or being taken.
module vertex_attribute_to_float4
    import va2f4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [3:0]  i_format_code,
    input  wire logic [8:0]  i_attr_offset,
    input  wire logic [4:0]  i_attr_size,
    input  wire logic [63:0] i_data_lo,
    input  wire logic [63:0] i_data_hi,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic        o_ok,
    output      logic [31:0] o_x_bits,
    output      logic [31:0] o_y_bits,
    output      logic [31:0] o_z_bits,
    output      logic [31:0] o_w_bits
);
    logic [7:0] r_stride;
    logic       r_v1, r_v2, r_v3;
    t_s1        r_s1, n_s1;
    t_s2        r_s2, n_s2;
    t_res       r_res, n_res;
    logic       w_adv;

    assign w_adv       = !r_v3 || i_ready;
    assign o_ready     = w_adv;
    assign o_cfg_ready = 1'b1;

    va2f4_check u_check (
        .i_fmt    (i_format_code),
        .i_off    (i_attr_offset),
        .i_size   (i_attr_size),
        .i_data   ({i_data_hi, i_data_lo}),
        .i_stride (r_stride),
        .o_s1     (n_s1)
    );
    va2f4_lanes u_lanes (.i_s1(r_s1), .o_s2(n_s2));
    va2f4_pack  u_pack  (.i_s2(r_s2), .o_res(n_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= 8'd0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_stride <= i_cfg_data;
            end
            if (w_adv) begin
                r_v1 <= i_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // payload advances with the stall, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_res <= n_res;
        end
    end

    assign o_valid  = r_v3;
    assign o_ok     = r_res.ok;
    assign o_x_bits = r_res.c[0];
    assign o_y_bits = r_res.c[1];
    assign o_z_bits = r_res.c[2];
    assign o_w_bits = r_res.c[3];
endmodule
`default_nettype wire
